// ===== rtl/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, widths, register map and constants of the lift position
// controller.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int POS_W      = 24;
  localparam int DRV_W      = 16;
  localparam int SPD_W      = 15;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIVD_W     = 16;
  localparam int REM_W      = DIVD_W + 1;
  localparam int DIV_STEPS  = SPD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DRV_W-1:0] drive_t;
  typedef logic [SPD_W-1:0]        speed_t;
  typedef logic [CNT_W-1:0]        count_t;

  localparam speed_t Q_ONE = 15'd16384;

  localparam logic [15:0] RST_TOLERANCE   = 16'd20;
  localparam logic [15:0] RST_SLOWDOWN    = 16'd500;
  localparam logic [15:0] RST_RECHECK     = 16'd10;
  localparam speed_t      RST_MIN_SPEED   = 15'd3277;
  localparam speed_t      RST_STALL_BONUS = 15'd164;
  localparam pos_t        RST_INTERFERE   = 24'sd1000;
  localparam pos_t        RST_SCORE       = 24'sd200;
  localparam speed_t      RST_SLOW_SPEED  = 15'd4915;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE   = 3'd0,
    REG_SLOWDOWN    = 3'd1,
    REG_RECHECK     = 3'd2,
    REG_MIN_SPEED   = 3'd3,
    REG_STALL_BONUS = 3'd4,
    REG_INTERFERE   = 3'd5,
    REG_SCORE       = 3'd6,
    REG_SLOW_SPEED  = 3'd7
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIFF  = 6'b000010,
    ST_CLASS = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    speed_t quot;
  } div_rsp_t;

endpackage

// ===== rtl/lpc_if.sv =====
// ----------------------------------------------------------------------------
// lpc_if
// Valid/ready channels of the lift position controller: tick items, result
// items and register writes.
// ----------------------------------------------------------------------------
interface lpc_in_if;
  logic          valid;
  logic          ready;
  lpc_pkg::pos_t position;
  lpc_pkg::pos_t target;
  logic          bottom_switch_raw;
  logic          jaws_shut;

  modport source (output valid, position, target, bottom_switch_raw, jaws_shut,
                  input ready);
  modport sink   (input valid, position, target, bottom_switch_raw, jaws_shut,
                  output ready);
endinterface

interface lpc_out_if;
  logic            valid;
  logic            ready;
  lpc_pkg::drive_t motor_drive;
  logic            on_target;
  logic            reset_encoder;

  modport source (output valid, motor_drive, on_target, reset_encoder, input ready);
  modport sink   (input valid, motor_drive, on_target, reset_encoder, output ready);
endinterface

interface lpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lpc_pkg::CFG_IDX_W-1:0]       index;
  logic [lpc_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lpc_divider.sv =====
// ----------------------------------------------------------------------------
// lpc_divider
// Serial restoring divider: quotient of dist * 2^14 / divisor for
// dist <= divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  lpc_pkg::div_req_t req,
  output lpc_pkg::div_rsp_t rsp
);

  logic [lpc_pkg::REM_W-1:0]     rem_r, rem_nxt;
  lpc_pkg::speed_t               quot_r, quot_nxt;
  logic [lpc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lpc_pkg::REM_W-1:0]     trial;
  logic [lpc_pkg::REM_W-1:0]     dvs;
  logic                          fits;

  always_comb begin
    dvs      = {1'b0, req.divisor};
    // first step compares the distance itself, later steps the doubled remainder
    trial    = (cnt_r == '0) ? rem_r : {rem_r[lpc_pkg::REM_W-2:0], 1'b0};
    fits     = (trial >= dvs);
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = {1'b0, req.dividend};
      quot_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? (trial - dvs) : trial;
      quot_nxt = {quot_r[lpc_pkg::SPD_W-2:0], fits};
      if (cnt_r == lpc_pkg::DIV_CNT_W'(lpc_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cnt_nxt  = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== rtl/lift_position_controller_top.sv =====
// ----------------------------------------------------------------------------
// lift_position_controller_top
// Lift position controller: one motor command per control tick item.
// ----------------------------------------------------------------------------
// An item that needs the proportional speed passes from acceptance to a valid
// result through these steps: the position difference, its classification, the
// serial divider (15 quotient bits at one per cycle, then handing back the
// quotient), adding minimum speed and stall bonus, and loading the output
// register. Items that land in the band, hit a limit or run at full or slow
// speed skip the divider. The input is not ready while an item is in work;
// the result sits in an output register, so the next item is accepted while
// it waits. Register writes are taken at any time, one per cycle.
module lift_position_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  lpc_in_if.sink     in_ch,
  lpc_out_if.source  out_ch,
  lpc_cfg_if.sink    cfg_ch
);

  lpc_pkg::state_t   state_r, state_nxt;

  logic [15:0]       tol_r, sd_r, recheck_r;
  lpc_pkg::speed_t   min_r, bonus_r, slow_r;
  lpc_pkg::pos_t     intf_r, score_r;

  lpc_pkg::count_t   tick_r, tick_nxt;
  lpc_pkg::pos_t     last_r, last_nxt;
  lpc_pkg::count_t   stall_r, stall_nxt;

  lpc_pkg::pos_t     pos_r, pos_nxt;
  lpc_pkg::pos_t     tgt_r, tgt_nxt;
  logic              pressed_r, pressed_nxt;
  logic              closed_r, closed_nxt;
  logic              neg_r, neg_nxt;
  logic [lpc_pkg::POS_W-1:0] dist_r, dist_nxt;
  logic [30:0]       prod_r;

  lpc_pkg::drive_t   drv_r, drv_nxt;
  logic              on_r, on_nxt;
  logic              rst_r, rst_nxt;

  logic              out_valid_r, out_valid_nxt;
  lpc_pkg::drive_t   out_drv_r;
  logic              out_on_r, out_rst_r;
  logic              load;

  lpc_pkg::div_req_t div_req;
  lpc_pkg::div_rsp_t div_rsp;

  logic              accept;
  lpc_pkg::count_t   tick_inc;
  logic [lpc_pkg::POS_W:0] d_pt, d_tp;
  logic              outside, fast, low_zone, high_zone;
  lpc_pkg::speed_t   slow_sat, sp;
  logic [31:0]       sum;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == lpc_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    tick_inc  = (tick_r == '1) ? tick_r : tick_r + 1'b1;
    d_pt      = {pos_r[lpc_pkg::POS_W-1], pos_r} - {tgt_r[lpc_pkg::POS_W-1], tgt_r};
    d_tp      = {tgt_r[lpc_pkg::POS_W-1], tgt_r} - {pos_r[lpc_pkg::POS_W-1], pos_r};
    outside   = dist_r > {8'd0, tol_r};
    fast      = (dist_r > {8'd0, sd_r}) || (sd_r == '0);
    low_zone  = pos_r <= score_r;
    high_zone = pos_r >= intf_r;
    slow_sat  = (slow_r > lpc_pkg::Q_ONE) ? lpc_pkg::Q_ONE : slow_r;
    sum       = {17'd0, div_rsp.quot} + {17'd0, min_r} + {1'b0, prod_r};
    sp        = (sum > {17'd0, lpc_pkg::Q_ONE}) ? lpc_pkg::Q_ONE
                                                : sum[lpc_pkg::SPD_W-1:0];
    load      = (state_r == lpc_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

    state_nxt   = state_r;
    tick_nxt    = tick_r;
    last_nxt    = last_r;
    stall_nxt   = stall_r;
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    pressed_nxt = pressed_r;
    closed_nxt  = closed_r;
    neg_nxt     = neg_r;
    dist_nxt    = dist_r;
    drv_nxt     = drv_r;
    on_nxt      = on_r;
    rst_nxt     = rst_r;
    div_req.start    = 1'b0;
    div_req.dividend = dist_r[lpc_pkg::DIVD_W-1:0];
    div_req.divisor  = sd_r;

    case (state_r)
      lpc_pkg::ST_IDLE: begin
        if (accept) begin
          pos_nxt     = in_ch.position;
          tgt_nxt     = in_ch.target;
          pressed_nxt = !in_ch.bottom_switch_raw;
          closed_nxt  = in_ch.jaws_shut;
          tick_nxt    = tick_inc;
          if (tick_inc >= recheck_r) begin
            if (last_r == in_ch.position) begin
              stall_nxt = (stall_r == '1) ? stall_r : stall_r + 1'b1;
            end else begin
              last_nxt = in_ch.position;
              tick_nxt = '0;
            end
          end
          state_nxt = lpc_pkg::ST_DIFF;
        end
      end
      lpc_pkg::ST_DIFF: begin
        neg_nxt   = d_pt[lpc_pkg::POS_W];
        dist_nxt  = d_pt[lpc_pkg::POS_W] ? d_tp[lpc_pkg::POS_W-1:0]
                                         : d_pt[lpc_pkg::POS_W-1:0];
        state_nxt = lpc_pkg::ST_CLASS;
      end
      lpc_pkg::ST_CLASS: begin
        drv_nxt   = '0;
        on_nxt    = 1'b0;
        rst_nxt   = 1'b0;
        state_nxt = lpc_pkg::ST_DONE;
        if (!outside) begin
          on_nxt    = 1'b1;
          stall_nxt = '0;
        end else if (!neg_r) begin
          // moving down
          if (pressed_r) begin
            rst_nxt = 1'b1;
          end else if (low_zone) begin
            drv_nxt = lpc_pkg::DRV_W'(-$signed({1'b0, slow_sat}));
          end else if (fast) begin
            drv_nxt = lpc_pkg::DRV_W'(-$signed({1'b0, lpc_pkg::Q_ONE}));
          end else begin
            div_req.start = 1'b1;
            state_nxt     = lpc_pkg::ST_DIV;
          end
        end else begin
          // moving up
          if (high_zone && closed_r) begin
            drv_nxt = '0;
          end else if (fast) begin
            drv_nxt = $signed({1'b0, lpc_pkg::Q_ONE});
          end else begin
            div_req.start = 1'b1;
            state_nxt     = lpc_pkg::ST_DIV;
          end
        end
      end
      lpc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = lpc_pkg::ST_SUM;
        end
      end
      lpc_pkg::ST_SUM: begin
        drv_nxt   = neg_r ? $signed({1'b0, sp}) : lpc_pkg::DRV_W'(-$signed({1'b0, sp}));
        state_nxt = lpc_pkg::ST_DONE;
      end
      lpc_pkg::ST_DONE: begin
        if (load) begin
          state_nxt = lpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpc_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    tgt_r     <= tgt_nxt;
    pressed_r <= pressed_nxt;
    closed_r  <= closed_nxt;
    neg_r     <= neg_nxt;
    dist_r    <= dist_nxt;
    drv_r     <= drv_nxt;
    on_r      <= on_nxt;
    rst_r     <= rst_nxt;
    prod_r    <= bonus_r * stall_r;
    if (load) begin
      out_drv_r <= drv_r;
      out_on_r  <= on_r;
      out_rst_r <= rst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpc_pkg::ST_IDLE;
      tick_r      <= '0;
      last_r      <= '0;
      stall_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      last_r      <= last_nxt;
      stall_r     <= stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r     <= lpc_pkg::RST_TOLERANCE;
      sd_r      <= lpc_pkg::RST_SLOWDOWN;
      recheck_r <= lpc_pkg::RST_RECHECK;
      min_r     <= lpc_pkg::RST_MIN_SPEED;
      bonus_r   <= lpc_pkg::RST_STALL_BONUS;
      intf_r    <= lpc_pkg::RST_INTERFERE;
      score_r   <= lpc_pkg::RST_SCORE;
      slow_r    <= lpc_pkg::RST_SLOW_SPEED;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (lpc_pkg::cfg_reg_t'(cfg_ch.index))
        lpc_pkg::REG_TOLERANCE:   tol_r     <= cfg_ch.data[15:0];
        lpc_pkg::REG_SLOWDOWN:    sd_r      <= cfg_ch.data[15:0];
        lpc_pkg::REG_RECHECK:     recheck_r <= cfg_ch.data[15:0];
        lpc_pkg::REG_MIN_SPEED:   min_r     <= cfg_ch.data[lpc_pkg::SPD_W-1:0];
        lpc_pkg::REG_STALL_BONUS: bonus_r   <= cfg_ch.data[lpc_pkg::SPD_W-1:0];
        lpc_pkg::REG_INTERFERE:   intf_r    <= $signed(cfg_ch.data[lpc_pkg::POS_W-1:0]);
        lpc_pkg::REG_SCORE:       score_r   <= $signed(cfg_ch.data[lpc_pkg::POS_W-1:0]);
        lpc_pkg::REG_SLOW_SPEED:  slow_r    <= cfg_ch.data[lpc_pkg::SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_drive   = out_drv_r;
  assign out_ch.on_target     = out_on_r;
  assign out_ch.reset_encoder = out_rst_r;

endmodule

// ===== rtl/lpc_checker.sv =====
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks of the lift position controller, bound to the top level.
// ----------------------------------------------------------------------------
module lpc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lpc_pkg::drive_t motor_drive,
  input logic            on_target,
  input logic            reset_encoder
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(motor_drive) &&
    $stable(on_target) && $stable(reset_encoder))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an item");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (motor_drive >= -16'sd16384) && (motor_drive <= 16'sd16384))
    else $error("motor drive out of range");

  a_on_target_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && on_target |-> (motor_drive == '0) && !reset_encoder)
    else $error("drive while on target");

  a_reset_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reset_encoder |-> (motor_drive == '0))
    else $error("drive while at bottom limit");

endmodule

bind lift_position_controller_top lpc_checker u_lpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .motor_drive   (out_ch.motor_drive),
  .on_target     (out_ch.on_target),
  .reset_encoder (out_ch.reset_encoder)
);
